// ===== rtl/rcpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpwd_pkg: shared types and constants of the rc pulse width decoder
// Request layouts, register indexes, reset values and the fixed divide by
// the timer ticks per microsecond.
// ----------------------------------------------------------------------------
package rcpwd_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = 2;
    localparam int TS_W       = 32;
    localparam int WIDTH_W    = 26;
    localparam int BAND_W     = 5;
    localparam int FLAGS_W    = 4;
    localparam int LIMIT_W    = 16;
    localparam int BASE_W     = 16;
    localparam int STEP_W     = 8;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_BANDS_DEF = 21;

    // timer ticks per microsecond, split as an odd factor times a power of two
    localparam int TICKS_PER_US = 80;
    localparam int DIV_SHIFT    = 4;
    localparam int DIV_ODD      = TICKS_PER_US >> DIV_SHIFT;
    localparam int RECIP_SHIFT  = 31;
    localparam int QUOT_W       = TS_W - DIV_SHIFT;
    localparam int RECIP_W      = 32;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));

    localparam logic [CFG_IDX_W-1:0] REG_STICK_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_STEP  = 3'd4;

    localparam logic [LIMIT_W-1:0] STICK_LOW_RST  = 16'd1300;
    localparam logic [LIMIT_W-1:0] STICK_HIGH_RST = 16'd1700;
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = 8'd2;
    localparam logic [BASE_W-1:0]  BAND_BASE_RST  = 16'd1100;
    localparam logic [STEP_W-1:0]  BAND_STEP_RST  = 8'd40;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [CH_W-1:0] channel;
        logic            pin_level;
        logic [TS_W-1:0] timestamp;
    } t_in_req;

    typedef struct packed {
        logic [BAND_W-1:0]  turning;
        logic [BAND_W-1:0]  throttle;
        logic [FLAGS_W-1:0] alt_flags;
        logic [WIDTH_W-1:0] width_us;
    } t_out_req;

endpackage

// ===== rtl/rc_pulse_width_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_width_decoder_core: four-channel rc receiver pulse decoder
// A request passes the input register, then the result register, where its result
// is valid. Throughput: one request per cycle unless i_out_stall holds the output; the
// per-request path is one 28x32 reciprocal multiply for the divide plus the
// band compares.
// Reset (i_rst_n low, synchronous) clears both stages, all channel state and
// loads the register reset values; a request can be taken right after.
// ----------------------------------------------------------------------------
module rc_pulse_width_decoder_core #(
    parameter int NUM_BANDS = rcpwd_pkg::NUM_BANDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rcpwd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rcpwd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rcpwd_pkg::t_in_req                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rcpwd_pkg::t_out_req                 o_out_data
);

    localparam int CHN     = rcpwd_pkg::CHANNELS;
    localparam int WIDTH_W = rcpwd_pkg::WIDTH_W;
    localparam int BAND_W  = rcpwd_pkg::BAND_W;
    localparam int HOLD_W  = rcpwd_pkg::HOLD_W;
    localparam int TS_W    = rcpwd_pkg::TS_W;
    localparam int QUOT_W  = rcpwd_pkg::QUOT_W;
    localparam int PROD_W  = QUOT_W + rcpwd_pkg::RECIP_W;
    localparam int BOUND_W = $clog2(65535 + 255 * (NUM_BANDS - 1) + 1);

    logic [rcpwd_pkg::LIMIT_W-1:0] r_stick_low;
    logic [rcpwd_pkg::LIMIT_W-1:0] r_stick_high;
    logic [HOLD_W-1:0]             r_hold_ticks;
    logic [rcpwd_pkg::BASE_W-1:0]  r_band_base;
    logic [rcpwd_pkg::STEP_W-1:0]  r_band_step;
    logic [BOUND_W-1:0]            r_bound [NUM_BANDS];

    logic [rcpwd_pkg::BASE_W-1:0]  n_band_base;
    logic [rcpwd_pkg::STEP_W-1:0]  n_band_step;
    logic [BOUND_W-1:0]            n_bound [NUM_BANDS];
    logic                          bound_we;

    logic               r_in_valid;
    rcpwd_pkg::t_in_req r_in;
    logic               r_out_valid;
    rcpwd_pkg::t_out_req r_out;
    logic               in_accept;
    logic               advance;

    logic [TS_W-1:0]    r_rise  [CHN];
    logic [WIDTH_W-1:0] r_pulse [CHN];
    logic [BAND_W-1:0]  r_turn;
    logic [BAND_W-1:0]  r_throttle;
    logic [HOLD_W-1:0]  r_cnt   [CHN];
    logic [CHN-1:0]     r_flag;

    logic [TS_W-1:0]    n_rise  [CHN];
    logic [WIDTH_W-1:0] n_pulse [CHN];
    logic [BAND_W-1:0]  n_turn;
    logic [BAND_W-1:0]  n_throttle;
    logic [HOLD_W-1:0]  n_cnt   [CHN];
    logic [CHN-1:0]     n_flag;
    rcpwd_pkg::t_out_req n_out;

    logic [TS_W-1:0]    diff;
    logic [PROD_W-1:0]  prod;
    logic [WIDTH_W-1:0] width_new;
    logic [WIDTH_W-1:0] search_width;
    logic               band_found;
    logic [BAND_W-1:0]  band_sel;
    logic               hit_done;

    // configuration and band bounds
    always_comb begin
        n_band_base = r_band_base;
        n_band_step = r_band_step;
        bound_we    = 1'b0;
        if (i_cfg_we && i_cfg_index == rcpwd_pkg::REG_BAND_BASE) begin
            n_band_base = i_cfg_data[rcpwd_pkg::BASE_W-1:0];
            bound_we    = 1'b1;
        end
        if (i_cfg_we && i_cfg_index == rcpwd_pkg::REG_BAND_STEP) begin
            n_band_step = i_cfg_data[rcpwd_pkg::STEP_W-1:0];
            bound_we    = 1'b1;
        end
        for (int i = 0; i < NUM_BANDS; i++) begin
            n_bound[i] = BOUND_W'(n_band_base) + BOUND_W'(n_band_step) * BOUND_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_low  <= rcpwd_pkg::STICK_LOW_RST;
            r_stick_high <= rcpwd_pkg::STICK_HIGH_RST;
            r_hold_ticks <= rcpwd_pkg::HOLD_TICKS_RST;
            r_band_base  <= rcpwd_pkg::BAND_BASE_RST;
            r_band_step  <= rcpwd_pkg::BAND_STEP_RST;
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_bound[i] <= BOUND_W'(rcpwd_pkg::BAND_BASE_RST)
                            + BOUND_W'(rcpwd_pkg::BAND_STEP_RST) * BOUND_W'(i);
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rcpwd_pkg::REG_STICK_LOW: begin
                        r_stick_low <= i_cfg_data[rcpwd_pkg::LIMIT_W-1:0];
                    end
                    rcpwd_pkg::REG_STICK_HIGH: begin
                        r_stick_high <= i_cfg_data[rcpwd_pkg::LIMIT_W-1:0];
                    end
                    rcpwd_pkg::REG_HOLD_TICKS: begin
                        r_hold_ticks <= i_cfg_data[HOLD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            r_band_base <= n_band_base;
            r_band_step <= n_band_step;
            if (bound_we) begin
                for (int i = 0; i < NUM_BANDS; i++) begin
                    r_bound[i] <= n_bound[i];
                end
            end
        end
    end

    // handshake
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // width in microseconds: shift out the power of two, then reciprocal multiply
    assign diff      = r_in.timestamp - r_rise[r_in.channel];
    assign prod      = PROD_W'(diff[TS_W-1:rcpwd_pkg::DIV_SHIFT]) * PROD_W'(rcpwd_pkg::RECIP);
    assign width_new = prod[rcpwd_pkg::RECIP_SHIFT +: WIDTH_W];

    always_comb begin
        n_rise     = r_rise;
        n_pulse    = r_pulse;
        n_turn     = r_turn;
        n_throttle = r_throttle;
        n_cnt      = r_cnt;
        n_flag     = r_flag;
        hit_done   = 1'b0;
        band_found = 1'b0;
        band_sel   = '0;
        n_out      = '0;

        if (r_in.kind == rcpwd_pkg::KIND_EDGE) begin
            if (r_in.pin_level) begin
                n_rise[r_in.channel] = r_in.timestamp;
            end else if (r_in.timestamp > r_rise[r_in.channel]) begin
                n_pulse[r_in.channel] = width_new;
            end
        end else begin
            // stick hold counters
            if (r_pulse[3] < WIDTH_W'(r_stick_low)) begin
                n_cnt[0] = r_cnt[0] + HOLD_W'(1);
            end else if (r_pulse[3] > WIDTH_W'(r_stick_high)) begin
                n_cnt[1] = r_cnt[1] + HOLD_W'(1);
            end
            if (r_pulse[1] < WIDTH_W'(r_stick_low)) begin
                n_cnt[2] = r_cnt[2] + HOLD_W'(1);
            end else if (r_pulse[1] > WIDTH_W'(r_stick_high)) begin
                n_cnt[3] = r_cnt[3] + HOLD_W'(1);
            end
            for (int i = 0; i < CHN; i++) begin
                if (!hit_done && n_cnt[i] == r_hold_ticks) begin
                    n_flag[i] = ~r_flag[i];
                    n_cnt[i]  = '0;
                    hit_done  = 1'b1;
                end
            end
        end

        // lowest band whose bound exceeds the width
        search_width = n_pulse[r_in.channel];
        for (int i = NUM_BANDS - 1; i >= 0; i--) begin
            if (search_width < WIDTH_W'(r_bound[i])) begin
                band_found = 1'b1;
                band_sel   = BAND_W'(i);
            end
        end
        if (r_in.kind == rcpwd_pkg::KIND_EDGE && band_found) begin
            if (r_in.channel == 2'd0) begin
                n_turn = band_sel;
            end else if (r_in.channel == 2'd2) begin
                n_throttle = band_sel;
            end
        end

        n_out.turning   = n_turn;
        n_out.throttle  = n_throttle;
        n_out.alt_flags = n_flag;
        if (r_in.kind == rcpwd_pkg::KIND_EDGE) begin
            n_out.width_us = search_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHN; i++) begin
                r_rise[i]  <= '0;
                r_pulse[i] <= '0;
                r_cnt[i]   <= '0;
            end
            r_turn     <= '0;
            r_throttle <= '0;
            r_flag     <= '0;
        end else if (advance) begin
            r_rise     <= n_rise;
            r_pulse    <= n_pulse;
            r_cnt      <= n_cnt;
            r_turn     <= n_turn;
            r_throttle <= n_throttle;
            r_flag     <= n_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the rc pulse width decoder core
// Drives edge and tick requests through the valid/stall handshake with
// bursts, gaps and receiver back-pressure, and keeps a local copy of the
// decoder state: channel rise times, pulse widths, turning and throttle
// bands, stick hold counters and alternate flags. A short table of hand
// picked requests comes first; random pulse trains, ticks and junk requests
// follow under several register settings, extremes included. Each result is
// compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;

    localparam int CHANNELS      = rcpwd_pkg::CHANNELS;
    localparam int CH_W          = rcpwd_pkg::CH_W;
    localparam int TS_W          = rcpwd_pkg::TS_W;
    localparam int WIDTH_W       = rcpwd_pkg::WIDTH_W;
    localparam int BAND_W        = rcpwd_pkg::BAND_W;
    localparam int FLAGS_W       = rcpwd_pkg::FLAGS_W;
    localparam int LIMIT_W       = rcpwd_pkg::LIMIT_W;
    localparam int BASE_W        = rcpwd_pkg::BASE_W;
    localparam int STEP_W        = rcpwd_pkg::STEP_W;
    localparam int HOLD_W        = rcpwd_pkg::HOLD_W;
    localparam int CFG_IDX_W     = rcpwd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = rcpwd_pkg::CFG_DATA_W;
    localparam int NUM_BANDS_DEF = rcpwd_pkg::NUM_BANDS_DEF;
    localparam int TICKS_PER_US  = rcpwd_pkg::TICKS_PER_US;

    localparam logic KIND_EDGE = rcpwd_pkg::KIND_EDGE;
    localparam logic KIND_TICK = rcpwd_pkg::KIND_TICK;

    localparam logic [CFG_IDX_W-1:0] REG_STICK_LOW  = rcpwd_pkg::REG_STICK_LOW;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_HIGH = rcpwd_pkg::REG_STICK_HIGH;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = rcpwd_pkg::REG_HOLD_TICKS;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_BASE  = rcpwd_pkg::REG_BAND_BASE;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_STEP  = rcpwd_pkg::REG_BAND_STEP;

    localparam logic [LIMIT_W-1:0] STICK_LOW_RST  = rcpwd_pkg::STICK_LOW_RST;
    localparam logic [LIMIT_W-1:0] STICK_HIGH_RST = rcpwd_pkg::STICK_HIGH_RST;
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = rcpwd_pkg::HOLD_TICKS_RST;
    localparam logic [BASE_W-1:0]  BAND_BASE_RST  = rcpwd_pkg::BAND_BASE_RST;
    localparam logic [STEP_W-1:0]  BAND_STEP_RST  = rcpwd_pkg::BAND_STEP_RST;

    typedef rcpwd_pkg::t_in_req  t_in_req;
    typedef rcpwd_pkg::t_out_req t_out_req;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES      = 7;
    localparam int MAX_SHOWN       = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_HOLD       = 150;
    localparam int TURN_CH         = 0;
    localparam int THROTTLE_CH     = 2;
    localparam int LEFT_STICK_CH   = 3;
    localparam int RIGHT_STICK_CH  = 1;
    localparam logic [WIDTH_W-1:0] WIDTH_SAT = '1;

    typedef struct packed {
        logic     typed;
        t_out_req want;
        t_in_req  req;
    } t_dir_row;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{1'b1, '{5'd0, 5'd0, 4'd0, 26'd0}, '{KIND_TICK, 2'd0, 1'b0, 32'd0}},
        // fall not later than rise is ignored
        '{1'b1, '{5'd0, 5'd0, 4'd0, 26'd0}, '{KIND_EDGE, 2'd1, 1'b1, 32'hFFFF_FFFF}},
        '{1'b1, '{5'd0, 5'd0, 4'd0, 26'd0}, '{KIND_EDGE, 2'd1, 1'b0, 32'd0}},
        // widest pulse, no band matches so throttle is kept
        '{1'b1, '{5'd0, 5'd0, 4'd0, 26'd0}, '{KIND_EDGE, 2'd2, 1'b1, 32'd0}},
        '{1'b1, '{5'd0, 5'd0, 4'd0, 26'd53687091},
            '{KIND_EDGE, 2'd2, 1'b0, 32'hFFFF_FFFF}},
        '{1'b0, '0, '{KIND_EDGE, 2'd2, 1'b1, 32'd1000}},
        '{1'b0, '0, '{KIND_EDGE, 2'd2, 1'b0, 32'd121000}},
        '{1'b0, '0, '{KIND_EDGE, 2'd0, 1'b1, 32'd5000}},
        '{1'b0, '0, '{KIND_EDGE, 2'd0, 1'b0, 32'd77079}},
        '{1'b0, '0, '{KIND_EDGE, 2'd0, 1'b1, 32'd0}},
        '{1'b0, '0, '{KIND_EDGE, 2'd0, 1'b0, 32'd151920}},
        '{1'b0, '0, '{KIND_EDGE, 2'd3, 1'b1, 32'd0}},
        '{1'b0, '0, '{KIND_EDGE, 2'd3, 1'b0, 32'd80000}},
        '{1'b0, '0, '{KIND_EDGE, 2'd1, 1'b1, 32'd0}},
        '{1'b0, '0, '{KIND_EDGE, 2'd1, 1'b0, 32'd160000}},
        '{1'b0, '0, '{KIND_TICK, 2'd0, 1'b0, 32'd0}},
        '{1'b0, '0, '{KIND_TICK, 2'd0, 1'b0, 32'd0}},
        '{1'b0, '0, '{KIND_TICK, 2'd0, 1'b0, 32'd0}},
        '{1'b0, '0, '{KIND_EDGE, 2'd3, 1'b1, 32'd500}},
        '{1'b0, '0, '{KIND_EDGE, 2'd3, 1'b0, 32'd500}},
        // tick with junk in the edge fields
        '{1'b0, '0, '{KIND_TICK, 2'd3, 1'b1, 32'hFFFF_FFFF}},
        '{1'b0, '0, '{KIND_EDGE, 2'd0, 1'b0, 32'd79}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_req               i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_req              o_out_data;

    rc_pulse_width_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    logic [TS_W-1:0]    rise_ts     [CHANNELS];
    logic [WIDTH_W-1:0] pulse_width [CHANNELS];
    logic [HOLD_W-1:0]  hold_cnt    [CHANNELS];
    logic [BAND_W-1:0]  turn_band;
    logic [BAND_W-1:0]  throttle_band;
    logic [FLAGS_W-1:0] alt_bits;

    logic [LIMIT_W-1:0] low_limit;
    logic [LIMIT_W-1:0] high_limit;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [BASE_W-1:0]  band_base;
    logic [STEP_W-1:0]  band_step;

    t_out_req    decoded_q [$];
    logic [31:0] timer_now;
    int          burst_left;
    int          errors;
    int          results_seen;
    int          edges_sent;
    int          ticks_sent;
    int          settings_used;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [BAND_W-1:0] band_search(logic [WIDTH_W-1:0] w,
                                                      logic [BAND_W-1:0] cur);
        logic [31:0] bound;
        for (int i = 0; i < NUM_BANDS_DEF; i++) begin
            bound = 32'(band_base) + 32'(band_step) * 32'(i);
            if (32'(w) < bound) return BAND_W'(i);
        end
        return cur;
    endfunction

    function automatic void stick_hold(logic [WIDTH_W-1:0] w, int lo, int hi);
        if (32'(w) < 32'(low_limit))
            hold_cnt[lo] = hold_cnt[lo] + 8'd1;
        else if (32'(w) > 32'(high_limit))
            hold_cnt[hi] = hold_cnt[hi] + 8'd1;
    endfunction

    function automatic t_out_req decode_request(t_in_req r);
        t_out_req    o;
        logic [31:0] w;
        bit          toggled;
        o = '0;
        toggled = 1'b0;
        if (r.kind == KIND_EDGE) begin
            if (r.pin_level) begin
                rise_ts[r.channel] = r.timestamp;
            end else if (r.timestamp > rise_ts[r.channel]) begin
                w = (r.timestamp - rise_ts[r.channel]) / 32'(TICKS_PER_US);
                pulse_width[r.channel] = (w > 32'(WIDTH_SAT)) ? WIDTH_SAT : w[WIDTH_W-1:0];
            end
            if (r.channel == CH_W'(TURN_CH))
                turn_band = band_search(pulse_width[TURN_CH], turn_band);
            else if (r.channel == CH_W'(THROTTLE_CH))
                throttle_band = band_search(pulse_width[THROTTLE_CH], throttle_band);
            o.width_us = pulse_width[r.channel];
        end else begin
            stick_hold(pulse_width[LEFT_STICK_CH], 0, 1);
            stick_hold(pulse_width[RIGHT_STICK_CH], 2, 3);
            for (int i = 0; i < CHANNELS; i++) begin
                if (!toggled && hold_cnt[i] == hold_ticks) begin
                    alt_bits[i] = ~alt_bits[i];
                    hold_cnt[i] = '0;
                    toggled = 1'b1;
                end
            end
        end
        o.turning   = turn_band;
        o.throttle  = throttle_band;
        o.alt_flags = alt_bits;
        return o;
    endfunction

    function automatic void note_error(string msg);
        errors++;
        if (errors <= MAX_SHOWN) $display("mismatch: %s", msg);
    endfunction

    task automatic check_result(t_out_req got);
        t_out_req want;
        results_seen++;
        if (decoded_q.size() == 0) begin
            note_error($sformatf(
                "result with nothing pending: turning %0d throttle %0d flags %h width %0d",
                got.turning, got.throttle, got.alt_flags, got.width_us));
            return;
        end
        want = decoded_q.pop_front();
        if (got.turning !== want.turning || got.throttle !== want.throttle ||
            got.alt_flags !== want.alt_flags || got.width_us !== want.width_us)
            note_error($sformatf(
                "result %0d exp/act turning %0d/%0d throttle %0d/%0d flags %h/%h width %0d/%0d",
                results_seen, want.turning, got.turning, want.throttle, got.throttle,
                want.alt_flags, got.alt_flags, want.width_us, got.width_us));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_STICK_LOW:  low_limit  = data[LIMIT_W-1:0];
            REG_STICK_HIGH: high_limit = data[LIMIT_W-1:0];
            REG_HOLD_TICKS: hold_ticks = data[HOLD_W-1:0];
            REG_BAND_BASE:  band_base  = data[BASE_W-1:0];
            REG_BAND_STEP:  band_step  = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int phase);
        logic [CFG_DATA_W-1:0] v [5];
        case (phase)
            0: v = '{STICK_LOW_RST, STICK_HIGH_RST, 16'(HOLD_TICKS_RST),
                     BAND_BASE_RST, 16'(BAND_STEP_RST)};
            1: v = '{default: '0};
            2: v = '{default: '1};
            default: v = '{16'($urandom_range(800, 1500)), 16'($urandom_range(1500, 2200)),
                           {8'($urandom), 8'($urandom_range(0, 6))},
                           16'($urandom_range(400, 1500)),
                           {8'($urandom), 8'($urandom_range(0, 255))}};
        endcase
        write_reg(REG_STICK_LOW, v[0]);
        write_reg(REG_STICK_HIGH, v[1]);
        write_reg(REG_HOLD_TICKS, v[2]);
        write_reg(REG_BAND_BASE, v[3]);
        write_reg(REG_BAND_STEP, v[4]);
        write_reg(REG_BAND_STEP + CFG_IDX_W'($urandom_range(1, 3)), 16'($urandom));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_item(t_in_req r, logic typed, t_out_req want);
        t_out_req pred;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = decode_request(r);
        decoded_q.push_back(typed ? want : pred);
        if (r.kind == KIND_EDGE) edges_sent++;
        else ticks_sent++;
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic offer(t_in_req r, ref int count);
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(60, 150);
            else burst_left = $urandom_range(1, 20);
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        burst_left--;
        send_item(r, 1'b0, '0);
        count++;
    endtask

    function automatic logic [31:0] pick_width();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = int'(band_base) - 40 +
                               int'($urandom_range(0, 22 * int'(band_step) + 80));
            5, 6: v = int'(low_limit) + int'($urandom_range(0, 6)) - 3;
            7: v = int'(high_limit) + int'($urandom_range(0, 6)) - 3;
            8: v = $urandom_range(0, 3000);
            default: v = $urandom_range(0, 53687091);
        endcase
        if (v < 0) v = 0;
        return 32'(v);
    endfunction

    function automatic t_in_req random_tick();
        t_in_req r;
        r.kind      = KIND_TICK;
        r.channel   = CH_W'($urandom);
        r.pin_level = 1'($urandom);
        r.timestamp = $urandom;
        return r;
    endfunction

    task automatic pulse_on(logic [CH_W-1:0] ch, ref int count);
        logic [31:0] w;
        t_in_req     r;
        w = pick_width();
        timer_now = timer_now + 32'($urandom_range(0, 200000));
        r = '{kind: KIND_EDGE, channel: ch, pin_level: 1'b1, timestamp: timer_now};
        offer(r, count);
        timer_now = timer_now + w * 32'(TICKS_PER_US) + 32'($urandom_range(0, 79));
        r.pin_level = 1'b0;
        r.timestamp = timer_now;
        offer(r, count);
    endtask

    // receiver: checks results and drives its own stall pattern
    initial begin
        int mode;
        int hold_left;
        int rx_cycle;
        mode = 0;
        hold_left = 0;
        rx_cycle = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_result(o_out_data);
            rx_cycle++;
            if (rx_cycle % 50 == 0) mode = $urandom_range(0, 3);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= 1'($urandom_range(0, 1));
                    2: i_out_stall <= (rx_cycle % 4 != 0);
                    default: i_out_stall <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycles, decoded_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int       phase_items;
        int       pick;
        bit       hold_asked;
        bit       drained_mid;
        t_out_req none;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        none = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            rise_ts[c]     = '0;
            pulse_width[c] = '0;
            hold_cnt[c]    = '0;
        end
        turn_band     = '0;
        throttle_band = '0;
        alt_bits      = '0;
        low_limit     = STICK_LOW_RST;
        high_limit    = STICK_HIGH_RST;
        hold_ticks    = HOLD_TICKS_RST;
        band_base     = BAND_BASE_RST;
        band_step     = BAND_STEP_RST;
        timer_now     = $urandom;
        burst_left    = 0;
        errors        = 0;
        results_seen  = 0;
        edges_sent    = 0;
        ticks_sent    = 0;
        settings_used = 1;
        hold_request  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (k > 0 && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 4));
            send_item(DIR_TABLE[k].req, DIR_TABLE[k].typed,
                      DIR_TABLE[k].typed ? DIR_TABLE[k].want : none);
        end
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_setting(p);
            phase_items = 0;
            hold_asked  = 1'b0;
            drained_mid = 1'b0;
            burst_left  = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                    pulse_on(CH_W'($urandom_range(0, 3)), phase_items);
                else if (pick < 16)
                    repeat ($urandom_range(1, 3)) offer(random_tick(), phase_items);
                else
                    offer(t_in_req'({4'($urandom), 32'($urandom)}), phase_items);
                if (!hold_asked && phase_items >= 60) begin
                    hold_asked = 1'b1;
                    hold_request = 1'b1;
                end
                if (!drained_mid && phase_items >= 120) begin
                    drained_mid = 1'b1;
                    wait_drained();
                    burst_left = 0;
                end
            end
            wait_drained();
        end

        $display("covered %0d edge and %0d tick requests under %0d register settings",
                 edges_sent, ticks_sent, settings_used);
        $display("%0d results checked, %0d mismatches", results_seen, errors);
        if (errors == 0 && decoded_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
